// ===== rtl/cdad_pkg.sv =====
// Shared types, constants and the month length table for the date adder.
// Used by cdad_ctrl, cdad_dp and calendar_date_add_days. No dependencies.
package cdad_pkg;

  localparam int DayW   = 5;
  localparam int MonthW = 4;
  localparam int YearW  = 16;
  localparam int AddW   = 12;
  // The running day holds start_day plus days_to_add before any month is taken off.
  localparam int SumW   = 13;
  // The year is reduced modulo 400 by eight shifted compare and subtract steps.
  localparam int RedSteps = 8;
  localparam int RedCntW  = $clog2(RedSteps);

  localparam logic [MonthW-1:0] MonthJan  = MonthW'(1);
  localparam logic [MonthW-1:0] MonthFeb  = MonthW'(2);
  localparam logic [MonthW-1:0] MonthApr  = MonthW'(4);
  localparam logic [MonthW-1:0] MonthJun  = MonthW'(6);
  localparam logic [MonthW-1:0] MonthSep  = MonthW'(9);
  localparam logic [MonthW-1:0] MonthNov  = MonthW'(11);
  localparam logic [MonthW-1:0] MonthDec  = MonthW'(12);
  localparam logic [YearW-1:0]  YearMax   = {YearW{1'b1}};
  localparam logic [YearW-1:0]  YearCycle = YearW'(400);
  localparam logic [YearW-1:0]  YearCent1 = YearW'(100);
  localparam logic [YearW-1:0]  YearCent2 = YearW'(200);
  localparam logic [YearW-1:0]  YearCent3 = YearW'(300);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_STEP
  } state_t;

  typedef struct packed {
    logic load;    // capture a new input transfer
    logic reduce;  // one modulo 400 step on the year
    logic step;    // take one month off the running day
    logic finish;  // copy the normalized date to the output register
  } cmd_t;

  typedef struct packed {
    logic reduce_done;  // the current reduce step is the last one
    logic need_step;    // the running day exceeds the current month length
  } sts_t;

  // Months outside 1..12 count as 31 days.
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] month,
                                                input logic leap);
    logic [DayW-1:0] len;
    begin
      case (month)
        MonthApr, MonthJun, MonthSep, MonthNov: len = DayW'(30);
        MonthFeb: len = leap ? DayW'(29) : DayW'(28);
        default:  len = DayW'(31);
      endcase
      return len;
    end
  endfunction

endpackage

// ===== rtl/cdad_ctrl.sv =====
// Controller for the date adder: sequences load, year reduction, month steps
// and the output register handshake. Depends on cdad_pkg.
module cdad_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  cdad_pkg::sts_t sts,
  output cdad_pkg::cmd_t cmd
);
  import cdad_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_stall       = 1'b1;
    out_valid_next = out_valid && out_stall;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd.reduce = 1'b1;
        if (sts.reduce_done) begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        if (sts.need_step) begin
          cmd.step = 1'b1;
        end else if (out_free) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_valid_from_step: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_STEP)
    else $error("output became valid without finishing a date");
  a_reduce_to_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REDUCE && sts.reduce_done) |=> state == ST_STEP)
    else $error("year reduction did not hand over to month stepping");
`endif

endmodule

// ===== rtl/cdad_dp.sv =====
// Datapath for the date adder: running day, month, year, year modulo 400,
// and the output register. Driven by cdad_ctrl commands. Depends on cdad_pkg.
module cdad_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  cdad_pkg::cmd_t                  cmd,
  output cdad_pkg::sts_t                  sts,
  input  logic [cdad_pkg::DayW-1:0]       start_day,
  input  logic [cdad_pkg::MonthW-1:0]     start_month,
  input  logic [cdad_pkg::YearW-1:0]      start_year,
  input  logic [cdad_pkg::AddW-1:0]       days_to_add,
  output logic [cdad_pkg::DayW-1:0]       result_day,
  output logic [cdad_pkg::MonthW-1:0]     result_month,
  output logic [cdad_pkg::YearW-1:0]      result_year,
  output logic                            year_overflow
);
  import cdad_pkg::*;

  logic [SumW-1:0]    day;
  logic [MonthW-1:0]  month;
  logic [YearW-1:0]   year;
  logic               ovf;
  logic [YearW-1:0]   ymod;
  logic [RedCntW-1:0] red_cnt;

  logic [YearW:0]     red_sub;
  logic               red_take;
  logic               leap;
  logic [DayW-1:0]    len;

  assign red_sub  = {1'b0, YearCycle} << red_cnt;
  assign red_take = {1'b0, ymod} >= red_sub;
  assign leap     = (ymod[1:0] == 2'b00) && (ymod != YearCent1) &&
                    (ymod != YearCent2) && (ymod != YearCent3);
  assign len      = month_len(month, leap);

  assign sts.reduce_done = (red_cnt == '0);
  assign sts.need_step   = day > SumW'(len);

  // Control-side counter for the reduction steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      red_cnt <= '0;
    end else if (cmd.load) begin
      red_cnt <= RedCntW'(RedSteps - 1);
    end else if (cmd.reduce && red_cnt != '0) begin
      red_cnt <= red_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      day   <= SumW'(start_day) + SumW'(days_to_add);
      month <= start_month;
      year  <= start_year;
      ymod  <= start_year;
      ovf   <= 1'b0;
    end else if (cmd.reduce) begin
      if (red_take) begin
        ymod <= ymod - red_sub[YearW-1:0];
      end
    end else if (cmd.step) begin
      day <= day - SumW'(len);
      if (month >= MonthDec) begin
        month <= MonthJan;
        if (year == YearMax) begin
          year <= '0;
          ymod <= '0;
          ovf  <= 1'b1;
        end else begin
          year <= year + 1'b1;
          ymod <= (ymod == YearCycle - 1'b1) ? '0 : ymod + 1'b1;
        end
      end else begin
        month <= month + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result_day    <= day[DayW-1:0];
      result_month  <= month;
      result_year   <= year;
      year_overflow <= ovf;
    end
  end

`ifndef ASSERT_OFF
  a_mod_range: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> ymod < YearCycle)
    else $error("year modulo 400 left its range");
  a_month_range: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> (month >= MonthJan && month <= MonthDec))
    else $error("month left 1..12 after a step");
  a_day_falls: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> day < $past(day))
    else $error("running day did not shrink on a month step");
`endif

endmodule

// ===== rtl/calendar_date_add_days.sv =====
// Top level of the Gregorian date adder: joins the controller and datapath.
// Depends on cdad_pkg, cdad_ctrl and cdad_dp.
//
// Usage: an input transfer carries a date (start_day, start_month, start_year)
// and days_to_add. It is taken at a rising edge where in_valid is high and
// in_stall is low. One result transfer follows on the output channel with the
// normalized date and year_overflow, taken where out_valid is high and
// out_stall is low.
// Sequence: after the input transfer, the year is reduced modulo 400 for the
// leap rule, then one month is taken off the running day per step until the
// day fits its month, then the output register is loaded once it is free.
// Throughput: one item at a time, set by the single month subtract loop; a new
// input is taken as soon as the previous date has moved to the output register,
// so the next item can work while the previous result waits.
// Reset (rst, synchronous, active high) returns the controller to idle and
// drops out_valid. While out_stall holds, the result stays stable and a
// finished date waits in the datapath until the output register is free.
module calendar_date_add_days (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [cdad_pkg::DayW-1:0]   start_day,
  input  logic [cdad_pkg::MonthW-1:0] start_month,
  input  logic [cdad_pkg::YearW-1:0]  start_year,
  input  logic [cdad_pkg::AddW-1:0]   days_to_add,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [cdad_pkg::DayW-1:0]   result_day,
  output logic [cdad_pkg::MonthW-1:0] result_month,
  output logic [cdad_pkg::YearW-1:0]  result_year,
  output logic                        year_overflow
);
  import cdad_pkg::*;

  // Commands flow from the controller into the datapath; status flows back.
  cmd_t cmd;
  sts_t sts;

  cdad_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  cdad_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .start_day     (start_day),
    .start_month   (start_month),
    .start_year    (start_year),
    .days_to_add   (days_to_add),
    .result_day    (result_day),
    .result_month  (result_month),
    .result_year   (result_year),
    .year_overflow (year_overflow)
  );

endmodule

// ===== bench/calendar_date_add_days_check.sv =====
`timescale 1ns / 100ps
// Checker for the date adder: watches both channels, predicts each normalized date
// and compares it field by field with the result transfers. Depends on cdad_pkg.
module calendar_date_add_days_check (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [cdad_pkg::DayW-1:0]   start_day,
  input  logic [cdad_pkg::MonthW-1:0] start_month,
  input  logic [cdad_pkg::YearW-1:0]  start_year,
  input  logic [cdad_pkg::AddW-1:0]   days_to_add,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [cdad_pkg::DayW-1:0]   result_day,
  input  logic [cdad_pkg::MonthW-1:0] result_month,
  input  logic [cdad_pkg::YearW-1:0]  result_year,
  input  logic                        year_overflow,
  output int                          errors,
  output int                          results_checked,
  output int                          pending,
  output int                          overflows_seen
);
  import cdad_pkg::*;

  localparam int MonthsPerYear = 12;

  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
    logic              overflow;
  } date_t;

  date_t expected_dates[$];

  initial begin
    errors          = 0;
    results_checked = 0;
    pending         = 0;
    overflows_seen  = 0;
  end

  // Months outside 1..12 are treated as 31 days long.
  function automatic int unsigned days_in_month(input int unsigned month,
                                                input int unsigned year);
    logic leap;
    leap = (((year % 4) == 0) && ((year % 100) != 0)) || ((year % 400) == 0);
    case (MonthW'(month))
      MonthApr, MonthJun, MonthSep, MonthNov: return 30;
      MonthFeb: return leap ? 29 : 28;
      default:  return 31;
    endcase
  endfunction

  // Walks month by month, the same way the datapath does, until the day fits.
  function automatic date_t add_days_to_date(input logic [DayW-1:0]   day,
                                             input logic [MonthW-1:0] month,
                                             input logic [YearW-1:0]  year,
                                             input logic [AddW-1:0]   count);
    int unsigned running;
    int unsigned mon;
    int unsigned yr;
    date_t       sum;
    running      = day + count;
    mon          = month;
    yr           = year;
    sum.overflow = 1'b0;
    while (running > days_in_month(mon, yr)) begin
      running -= days_in_month(mon, yr);
      mon++;
      if (mon > MonthsPerYear) begin
        mon = MonthJan;
        if (yr == YearMax) begin
          yr           = 0;
          sum.overflow = 1'b1;
        end else begin
          yr++;
        end
      end
    end
    sum.day   = DayW'(running);
    sum.month = MonthW'(mon);
    sum.year  = YearW'(yr);
    return sum;
  endfunction

  task automatic compare_field(input string field, input logic [YearW-1:0] want,
                               input logic [YearW-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // The output side is handled first so that a result never meets the date
  // that enters in the same cycle.
  always @(posedge clk) begin
    date_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_dates.size() == 0) begin
          errors++;
          $display("%0t: result transfer with no date outstanding, got %0d-%0d-%0d",
                   $time, result_year, result_month, result_day);
        end else begin
          want = expected_dates.pop_front();
          compare_field("result_day", want.day, result_day);
          compare_field("result_month", want.month, result_month);
          compare_field("result_year", want.year, result_year);
          compare_field("year_overflow", want.overflow, year_overflow);
          results_checked++;
          if (want.overflow) overflows_seen++;
        end
      end
      if (in_valid && !in_stall) begin
        expected_dates.push_back(add_days_to_date(start_day, start_month, start_year,
                                                  days_to_add));
      end
      pending = expected_dates.size();
    end
  end

endmodule

// ===== bench/calendar_date_add_days_test.sv =====
`timescale 1ns / 100ps
// Top of the date adder testbench: clock, reset, stimulus, output stalls and verdict.
// Depends on cdad_pkg, calendar_date_add_days and calendar_date_add_days_check.
module calendar_date_add_days_test;
  import cdad_pkg::*;

  // Longest stretch without any transfer before the run is declared hung. It
  // lies well above the longest date, the long output hold-off and the random
  // stalls added together, so this leaves a wide margin.
  localparam int WatchdogLimit = 4000;
  localparam int HoldCycles    = 300;
  localparam int DrainCycles   = 160;
  localparam int ItemsPerPhase = 150;

  // Idling schemes for the random part of the run.
  typedef enum int {
    PH_STEADY,
    PH_SENDER_IDLE,
    PH_RECEIVER_STALL,
    PH_BOTH_IDLE,
    PH_COUNT
  } idle_phase_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [DayW-1:0]   start_day;
  logic [MonthW-1:0] start_month;
  logic [YearW-1:0]  start_year;
  logic [AddW-1:0]   days_to_add;
  logic              out_valid;
  logic              out_stall;
  logic [DayW-1:0]   result_day;
  logic [MonthW-1:0] result_month;
  logic [YearW-1:0]  result_year;
  logic              year_overflow;

  int   errors;
  int   results_checked;
  int   pending;
  int   overflows_seen;
  int   dates_sent;
  int   holds_done;
  int   quiet_cycles;
  int   send_idle_pct;
  int   recv_stall_pct;
  logic hold_request;

  calendar_date_add_days DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .start_day     (start_day),
    .start_month   (start_month),
    .start_year    (start_year),
    .days_to_add   (days_to_add),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_day    (result_day),
    .result_month  (result_month),
    .result_year   (result_year),
    .year_overflow (year_overflow)
  );

  calendar_date_add_days_check date_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .start_day       (start_day),
    .start_month     (start_month),
    .start_year      (start_year),
    .days_to_add     (days_to_add),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .result_day      (result_day),
    .result_month    (result_month),
    .result_year     (result_year),
    .year_overflow   (year_overflow),
    .errors          (errors),
    .results_checked (results_checked),
    .pending         (pending),
    .overflows_seen  (overflows_seen)
  );

  // 8 ns period: four high, four low.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Offers one date and holds it steady until the block takes it. Before the
  // offer the sender may sit idle for a random number of cycles, drawn once
  // per cycle against the idle percentage of the current phase.
  task automatic send_date(input logic [DayW-1:0] day, input logic [MonthW-1:0] month,
                           input logic [YearW-1:0] year, input logic [AddW-1:0] count);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    start_day   <= day;
    start_month <= month;
    start_year  <= year;
    days_to_add <= count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    dates_sent++;
  endtask

  // Output side. It stalls at random per the current phase, and when asked it
  // holds off for a long stretch so that the block fills up and pushes back
  // on its input while the sender keeps offering dates.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        holds_done++;
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: any cycle with a transfer on either channel clears the count.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no transfer for %0d cycles, %0d dates outstanding",
                 $time, quiet_cycles, pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int unsigned       pick;
    int unsigned       odd;
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
    logic [AddW-1:0]   count;

    rst            = 1'b1;
    in_valid       = 1'b0;
    start_day      = '0;
    start_month    = MonthJan;
    start_year     = '0;
    days_to_add    = '0;
    dates_sent     = 0;
    holds_done     = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed dates, sent back to back.
    // Day zero with nothing added comes back as day zero.
    send_date(DayW'(0), MonthJan, YearW'(2024), AddW'(0));
    send_date(DayW'(0), MonthDec, YearW'(0), AddW'(0));
    // February in leap and common years, centuries included; year 0 is leap.
    send_date(DayW'(28), MonthFeb, YearW'(2024), AddW'(1));
    send_date(DayW'(28), MonthFeb, YearW'(2023), AddW'(1));
    send_date(DayW'(28), MonthFeb, YearW'(1900), AddW'(1));
    send_date(DayW'(28), MonthFeb, YearW'(2000), AddW'(1));
    send_date(DayW'(28), MonthFeb, YearW'(0), AddW'(1));
    // A 30 day month given day 31 is pushed into the next month.
    send_date(DayW'(31), MonthApr, YearW'(1999), AddW'(0));
    // Month out of range: from 0 a step stays in its year, from 13..15 it rolls into the next one.
    send_date(DayW'(31), MonthW'(0), YearW'(500), AddW'(0));
    send_date(DayW'(31), MonthW'(0), YearW'(500), AddW'(1));
    send_date(DayW'(20), MonthW'(13), YearW'(77), AddW'(20));
    send_date(DayW'(0), MonthW'(15), YearW'(77), AddW'(0));
    send_date(DayW'(31), MonthW'(15), YearMax, AddW'(1));
    // Year wrap past the top of the range sets the overflow flag.
    send_date(DayW'(31), MonthDec, YearMax, AddW'(1));
    send_date(DayW'(31), MonthDec, YearMax, AddW'(4095));
    send_date(DayW'(1), MonthNov, YearMax, AddW'(61));
    // Field extremes.
    send_date(DayW'(31), MonthJan, YearW'(0), AddW'(4095));
    send_date(DayW'(31), MonthW'(15), YearMax, AddW'(4095));
    send_date(DayW'(0), MonthSep, YearW'(65535 - 11), AddW'(4095));

    // Random dates in four idling phases. The long output hold-off is asked
    // for at the start of the steady phase, where the sender never idles.
    for (int phase = 0; phase < PH_COUNT; phase++) begin
      case (idle_phase_t'(phase))
        PH_STEADY: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_request   = 1'b1;
        end
        PH_SENDER_IDLE: begin
          send_idle_pct  = 79;
          recv_stall_pct = 0;
        end
        PH_RECEIVER_STALL: begin
          send_idle_pct  = 0;
          recv_stall_pct = 79;
        end
        default: begin
          send_idle_pct  = 9;
          recv_stall_pct = 9;
        end
      endcase
      repeat (ItemsPerPhase) begin
        // Mostly valid months, now and then 0 or 13..15.
        if ($urandom_range(9) == 0) begin
          odd   = $urandom_range(3);
          month = (odd == 0) ? MonthW'(0) : MonthW'(MonthDec + odd);
        end else begin
          month = MonthW'($urandom_range(12, 1));
        end
        day = ($urandom_range(9) < 7) ? DayW'($urandom_range(28, 1))
                                      : DayW'($urandom_range(31, 0));
        // Years: anywhere, close to the wrap, around century boundaries, or tiny.
        pick = $urandom_range(9);
        if (pick < 4)      year = YearW'($urandom_range(65535));
        else if (pick < 6) year = YearMax - YearW'($urandom_range(15));
        else if (pick < 8) year = YearW'(100 * $urandom_range(655) + $urandom_range(4) - 2);
        else               year = YearW'($urandom_range(3));
        // Mostly short spans keep the run quick; three in ten reach the full range.
        pick = $urandom_range(9);
        if (pick < 4)      count = AddW'($urandom_range(40));
        else if (pick < 7) count = AddW'($urandom_range(400));
        else               count = AddW'($urandom_range(4095));
        send_date(day, month, year, count);
      end
    end
    in_valid <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    // Let every outstanding date come back, then watch for strays.
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk);

    $display("Ran %0d dates through four idling phases and %0d long output hold-off(s).",
             dates_sent, holds_done);
    $display("Checked %0d results, %0d with year overflow; %0d mismatch(es).",
             results_checked, overflows_seen, errors);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
